>>> rtl/lnr_pkg.sv
package lnr_pkg;

  localparam int unsigned XW = 16;
  localparam int unsigned RSTDW = 24;
  localparam logic [RSTDW-1:0] RSTD_SAT = 24'hFFFFFF;
  localparam logic signed [XW-1:0] GAMMA_ONE = 16'sd256;

  localparam logic [1:0] REG_ROW_LEN = 2'd0;
  localparam logic [1:0] REG_EPS = 2'd1;
  localparam logic [1:0] REG_USE_GAMMA = 2'd2;
  localparam logic [1:0] REG_USE_BETA = 2'd3;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] gamma;
    logic signed [15:0] beta;
  } lnr_in_t;

  typedef struct packed {
    logic signed [15:0] y;
    logic signed [15:0] row_mean;
    logic [23:0] row_rstd;
    logic last;
  } lnr_out_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MEAN,
    ST_VAR_RD,
    ST_VAR_ACC,
    ST_VDIV,
    ST_RDIV,
    ST_SQRT,
    ST_OUT_RD,
    ST_OUT_MUL1,
    ST_OUT_MUL2,
    ST_OUT_EMIT
  } lnr_state_e;

endpackage

>>> rtl/lnr_ram.sv
module lnr_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/lnr_divsqrt.sv
module lnr_divsqrt
  import lnr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        sqrt_i,
  input  logic [48:0] num_i,
  input  logic [32:0] den_i,
  output logic        done_o,
  output logic [48:0] quo_o,
  output logic [32:0] rem_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        sqrt_q, sqrt_d;
  logic [49:0] num_q, num_d;
  logic [32:0] den_q, den_d;
  logic [49:0] rem_q, rem_d;
  logic [48:0] quo_q, quo_d;
  logic [49:0] trial;
  logic [49:0] rem_sh;
  logic [5:0]  last_cnt;

  assign last_cnt = sqrt_q ? 6'd25 : 6'd49;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    sqrt_d = sqrt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    done_d = 1'b0;
    rem_sh = '0;
    trial  = '0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sqrt_d = sqrt_i;
      num_d  = {1'b0, num_i};
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      if (sqrt_q) begin
        rem_sh = {rem_q[47:0], num_q[49:48]};
        trial  = {quo_q[47:0], 2'b01} ;
        num_d  = {num_q[47:0], 2'b00};
      end else begin
        rem_sh = {rem_q[48:0], num_q[48]};
        trial  = {17'd0, den_q};
        num_d  = {num_q[48:0], 1'b0};
      end
      if (rem_sh >= trial) begin
        rem_d = rem_sh - trial;
        quo_d = {quo_q[47:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[47:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == last_cnt - 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      sqrt_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      sqrt_q <= sqrt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[32:0];

endmodule

>>> rtl/layer_norm_row_core.sv
// layer_norm_row_core: layer normalization of one row, Q8.8 fixed point.
// Input: an element x with its column's gamma and beta is transferred at a
// rising edge where start is high and busy is low. Elements are written
// to three 64-entry single-port-read RAMs and x is added to a running sum.
// Configuration: cfg_we_i, cfg_idx_i, cfg_data_i write row_len, eps,
// use_gamma, use_beta at any edge; write only while the block is idle.
// Loading accepts one element per cycle. The element that fills the row raises
// busy; the block then derives the mean with a bit-serial divider, rereads
// the row to sum squared deviations, divides by the count, divides 2^48 by
// var+eps and takes the root (both skipped when var+eps is zero, giving a
// saturated rstd). It then rereads the row once more and emits one result per
// element (RAM read, two registered multiplies, shift, add beta and clamp),
// marked by out_valid_o with last set on the final one; busy falls as that
// one appears.
// The receiver cannot stall: each result is present for one cycle only.
// Reset clears the fill count, running sum, state and registers to row_len
// 64, eps 1, use_gamma 1, use_beta 1; RAM contents stay undefined.
module layer_norm_row_core
  import lnr_pkg::*;
#(
  parameter int unsigned RowLenMax = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  lnr_in_t  in_i,
  output logic     out_valid_o,
  output lnr_out_t out_o,
  input  logic     cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(RowLenMax);
  localparam int unsigned CW = $clog2(RowLenMax + 1);

  lnr_state_e state_q, state_d;
  logic [6:0]  row_len_q;
  logic [15:0] eps_q;
  logic        use_gamma_q, use_beta_q;
  logic [CW-1:0] fill_q, fill_d;
  logic signed [22:0] sum_q, sum_d;
  logic [AW-1:0] idx_q, idx_d;
  logic signed [15:0] mean_q, mean_d;
  logic [39:0] sumsq_q, sumsq_d;
  logic [23:0] rstd_q, rstd_d;
  logic signed [16:0] dev_q, dev_d;
  logic signed [41:0] p1_q, p1_d;
  logic signed [58:0] p2_q, p2_d;
  logic signed [15:0] beta_q, beta_d;
  logic        out_valid_d;
  lnr_out_t    out_d;
  logic [CW-1:0] eff_len;
  logic        accept;
  logic [AW-1:0] waddr, raddr;
  logic [15:0] x_rd, g_rd, b_rd;
  logic        div_start, div_sqrt, div_done;
  logic        div_busy_q;
  logic [48:0] div_num, div_quo;
  logic [32:0] div_den, div_rem;
  logic [22:0] sum_abs;
  logic signed [16:0] d_c;
  logic [33:0] sq_c;
  logic [32:0] vpe;
  logic signed [15:0] g_c;
  logic signed [42:0] q_c;
  logic signed [43:0] y_c;
  logic        unused_sig;

  function automatic logic [22:0] sum_abs_next(input logic signed [22:0] s);
    sum_abs_next = s[22] ? 23'(-s) : 23'(s);
  endfunction

  assign busy   = (state_q != ST_LOAD);
  assign accept = start && !busy;

  always_comb begin
    if (row_len_q == 7'd0) begin
      eff_len = CW'(1);
    end else if (32'(row_len_q) > RowLenMax) begin
      eff_len = CW'(RowLenMax);
    end else begin
      eff_len = CW'(row_len_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q   <= 7'd64;
      eps_q       <= 16'd1;
      use_gamma_q <= 1'b1;
      use_beta_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROW_LEN:   row_len_q   <= cfg_data_i[6:0];
        REG_EPS:       eps_q       <= cfg_data_i;
        REG_USE_GAMMA: use_gamma_q <= cfg_data_i[0];
        REG_USE_BETA:  use_beta_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign waddr = fill_q[AW-1:0];

  lnr_ram #(.Width(16), .Depth(RowLenMax)) u_x_ram (
    .clk_i, .we_i(accept), .waddr_i(waddr), .wdata_i(in_i.x),
    .raddr_i(raddr), .rdata_o(x_rd)
  );
  lnr_ram #(.Width(16), .Depth(RowLenMax)) u_g_ram (
    .clk_i, .we_i(accept), .waddr_i(waddr), .wdata_i(in_i.gamma),
    .raddr_i(raddr), .rdata_o(g_rd)
  );
  lnr_ram #(.Width(16), .Depth(RowLenMax)) u_b_ram (
    .clk_i, .we_i(accept), .waddr_i(waddr), .wdata_i(in_i.beta),
    .raddr_i(raddr), .rdata_o(b_rd)
  );

  lnr_divsqrt u_divsqrt (
    .clk_i, .rst_ni, .start_i(div_start), .sqrt_i(div_sqrt),
    .num_i(div_num), .den_i(div_den), .done_o(div_done),
    .quo_o(div_quo), .rem_o(div_rem)
  );

  assign sum_abs = sum_q[22] ? 23'(-sum_q) : 23'(sum_q);
  assign d_c     = 17'(signed'(x_rd)) - 17'(mean_q);
  assign sq_c    = 34'(d_c * d_c);
  assign vpe     = 33'(sumsq_q[32:0]) + 33'(eps_q);
  assign g_c     = use_gamma_q ? signed'(g_rd) : GAMMA_ONE;
  assign q_c     = 43'(p2_q >>> 24);
  assign y_c     = 44'(q_c) + 44'(beta_q);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    idx_d       = idx_q;
    mean_d      = mean_q;
    sumsq_d     = sumsq_q;
    rstd_d      = rstd_q;
    dev_d       = dev_q;
    p1_d        = p1_q;
    p2_d        = p2_q;
    beta_d      = beta_q;
    raddr       = idx_q;
    div_start   = 1'b0;
    div_sqrt    = 1'b0;
    div_num     = '0;
    div_den     = '0;
    out_valid_d = 1'b0;
    out_d       = out_o;
    unique case (state_q)
      ST_LOAD: begin
        if (accept) begin
          sum_d  = sum_q + 23'(in_i.x);
          fill_d = fill_q + CW'(1);
          if (fill_q + CW'(1) >= eff_len) begin
            state_d   = ST_MEAN;
            div_start = 1'b1;
            div_num   = 49'(sum_abs_next(sum_q + 23'(in_i.x)));
            div_den   = 33'(fill_q + CW'(1));
          end
        end
      end
      ST_MEAN: begin
        if (div_done) begin
          mean_d  = sum_q[22] ? 16'(-signed'(div_quo[22:0])) : 16'(div_quo[22:0]);
          idx_d   = '0;
          sumsq_d = '0;
          state_d = ST_VAR_RD;
        end
      end
      ST_VAR_RD: begin
        state_d = ST_VAR_ACC;
      end
      ST_VAR_ACC: begin
        sumsq_d = sumsq_q + 40'(sq_c);
        if (CW'(idx_q) + CW'(1) >= fill_q) begin
          state_d   = ST_VDIV;
        end else begin
          idx_d   = idx_q + AW'(1);
          raddr   = idx_q + AW'(1);
          state_d = ST_VAR_RD;
        end
      end
      ST_VDIV: begin
        if (!div_done && !div_busy_q) begin
          div_start = 1'b1;
          div_num   = 49'(sumsq_q);
          div_den   = 33'(fill_q);
        end
        if (div_done) begin
          sumsq_d = 40'(div_quo[32:0]);
          state_d = ST_RDIV;
        end
      end
      ST_RDIV: begin
        if (vpe == 33'd0) begin
          rstd_d  = RSTD_SAT;
          idx_d   = '0;
          raddr   = '0;
          state_d = ST_OUT_RD;
        end else begin
          if (!div_done && !div_busy_q) begin
            div_start = 1'b1;
            div_num   = 49'h1_0000_0000_0000;
            div_den   = vpe;
          end
          if (div_done) begin
            div_start = 1'b1;
            div_sqrt  = 1'b1;
            div_num   = div_quo;
            state_d   = ST_SQRT;
          end
        end
      end
      ST_SQRT: begin
        if (div_done) begin
          rstd_d  = (div_quo[48:24] != '0) ? RSTD_SAT : div_quo[23:0];
          idx_d   = '0;
          raddr   = '0;
          state_d = ST_OUT_RD;
        end
      end
      ST_OUT_RD: begin
        state_d = ST_OUT_MUL1;
      end
      ST_OUT_MUL1: begin
        dev_d   = d_c;
        p1_d    = 42'(d_c * signed'({1'b0, rstd_q}));
        p2_d    = 59'(g_c);
        beta_d  = use_beta_q ? signed'(b_rd) : 16'sd0;
        state_d = ST_OUT_MUL2;
      end
      ST_OUT_MUL2: begin
        p2_d    = 59'(p1_q * signed'(p2_q[15:0]));
        state_d = ST_OUT_EMIT;
      end
      ST_OUT_EMIT: begin
        out_valid_d    = 1'b1;
        out_d.y        = (y_c > 44'sd32767) ? 16'sd32767 :
                         (y_c < -44'sd32768) ? -16'sd32768 : 16'(y_c);
        out_d.row_mean = mean_q;
        out_d.row_rstd = rstd_q;
        out_d.last     = (CW'(idx_q) + CW'(1) >= fill_q);
        if (CW'(idx_q) + CW'(1) >= fill_q) begin
          fill_d  = '0;
          sum_d   = '0;
          state_d = ST_LOAD;
        end else begin
          idx_d   = idx_q + AW'(1);
          raddr   = idx_q + AW'(1);
          state_d = ST_OUT_RD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
    end else if (div_start) begin
      div_busy_q <= 1'b1;
    end else if (div_done) begin
      div_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      fill_q      <= '0;
      sum_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      out_valid_o <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    mean_q  <= mean_d;
    sumsq_q <= sumsq_d;
    rstd_q  <= rstd_d;
    dev_q   <= dev_d;
    p1_q    <= p1_d;
    p2_q    <= p2_d;
    beta_q  <= beta_d;
    out_o   <= out_d;
  end

  assign unused_sig = ^{dev_q, div_rem, sum_abs};

endmodule

>>> rtl/lnr_checker.sv
module lnr_checker
  import lnr_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     out_valid_o,
  input lnr_out_t out_o
);

  a_no_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy || $past(busy)) else $error("result while idle");

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.last) |-> !busy) else $error("busy after last");

  a_no_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o) else $error("results back to back");

  a_rstd_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_o.last) |=> ##3 (out_valid_o && $stable(out_o.row_rstd)))
    else $error("rstd changed within row");

endmodule

bind layer_norm_row_core lnr_checker u_lnr_checker (
  .clk_i, .rst_ni, .start, .busy, .out_valid_o, .out_o
);
